FILE: hdl/page_frame_allocator_assert.svh
// ---------------------------------------------------------------------------
// Page frame allocator assertion macros
// Shorthand for the concurrent checks of the allocator, clocked on aclk and
// disabled while aresetn is low.
// ---------------------------------------------------------------------------
`ifndef PAGE_FRAME_ALLOCATOR_ASSERT_SVH
`define PAGE_FRAME_ALLOCATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PFA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PFA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/pfa_pkg.sv
// ---------------------------------------------------------------------------
// Page frame allocator package
// Field widths, operation and status codes, register map and default sizes.
// ---------------------------------------------------------------------------
package pfa_pkg;

    localparam int ADDR_W     = 52;
    localparam int PAGE_W     = 12;
    localparam int FN_W       = ADDR_W - PAGE_W;
    localparam int CNT_W      = 13;
    localparam int KIND_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int S_TDATA_W  = 72;
    localparam int M_TDATA_W  = 56;
    localparam int WORD_W     = 64;
    localparam int CHUNK_W    = 16;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_REGIONS = 2;

    localparam int REGIONS_DEF           = 2;
    localparam int FRAMES_PER_REGION_DEF = 4096;
    localparam int CACHE_DEPTH_DEF       = 16;

    localparam logic [WORD_W-1:0] FULL_WORD = 64'hffff_ffff_ffff_ffff;

    localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RESERVE = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_FREE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD     = 2'd2;

    localparam logic [1:0] REG_REGION0_BASE   = 2'd0;
    localparam logic [1:0] REG_REGION0_FRAMES = 2'd1;
    localparam logic [1:0] REG_REGION1_BASE   = 2'd2;
    localparam logic [1:0] REG_REGION1_FRAMES = 2'd3;

    localparam logic [1:0] REG_BASE_IDX [CFG_REGIONS] = '{REG_REGION0_BASE, REG_REGION1_BASE};
    localparam logic [1:0] REG_FRAMES_IDX [CFG_REGIONS] =
        '{REG_REGION0_FRAMES, REG_REGION1_FRAMES};

endpackage

FILE: hdl/page_frame_allocator.sv
// ---------------------------------------------------------------------------
// Page frame allocator
// Bitmap allocator over configured physical regions with a LIFO cache of
// recently freed frames per region.
// ---------------------------------------------------------------------------
// One transaction is handled at a time under a small sequencer around the
// bitmap RAM, which gives one 64-frame word per cycle. After reset the block
// clears all REGIONS*ceil(FRAMES_PER_REGION/64) bitmap words (128 by default)
// before it takes its first transaction. An allocation served from a cache
// passes through region, pop, set and done states; one that scans visits each
// region in turn and examines one bitmap word at a time. A free tests regions
// until one holds the frame, then clears its bit; a reserve tests regions,
// checks the range and then sets one bitmap word at a time. Invalid requests
// go straight to the done state. The result register lets a new transaction
// start while the previous result waits.
`include "page_frame_allocator_assert.svh"

module page_frame_allocator import pfa_pkg::*; #(
    parameter int REGIONS           = REGIONS_DEF,
    parameter int FRAMES_PER_REGION = FRAMES_PER_REGION_DEF,
    parameter int CACHE_DEPTH       = CACHE_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // phys_addr [51:0], frame_count [64:52], zero padding above
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // kind [1:0]
    input  logic [KIND_W-1:0]     s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // frame_addr [51:0], status [53:52], zero padding above
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int FW    = $clog2(FRAMES_PER_REGION + 1);
    localparam int IW    = $clog2(FRAMES_PER_REGION);
    localparam int WPR   = (FRAMES_PER_REGION + 63) / 64;
    localparam int WW    = (WPR > 1) ? $clog2(WPR) : 1;
    localparam int BDEPTH = REGIONS * WPR;
    localparam int BAW   = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;
    localparam int CDEPTH = REGIONS * CACHE_DEPTH;
    localparam int CAW   = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
    localparam int CCW   = $clog2(CACHE_DEPTH + 1);
    localparam int RW    = (REGIONS > 1) ? $clog2(REGIONS) : 1;
    localparam int FSW   = (FW > CNT_W) ? FW : CNT_W;

    typedef enum logic [11:0] {
        ST_IDLE    = 12'b0000_0000_0001,
        ST_CLEAR   = 12'b0000_0000_0010,
        ST_A_REGION = 12'b0000_0000_0100,
        ST_A_POP   = 12'b0000_0000_1000,
        ST_A_SET   = 12'b0000_0001_0000,
        ST_A_SCAN  = 12'b0000_0010_0000,
        ST_A_PICK  = 12'b0000_0100_0000,
        ST_FIND    = 12'b0000_1000_0000,
        ST_F_CLR   = 12'b0001_0000_0000,
        ST_R_CHECK = 12'b0010_0000_0000,
        ST_R_RUN   = 12'b0100_0000_0000,
        ST_DONE    = 12'b1000_0000_0000
    } state_t;

    function automatic logic [BAW-1:0] bm_addr(input logic [31:0] r, input logic [31:0] w);
        return BAW'(r * 32'(WPR) + w);
    endfunction

    function automatic logic [CAW-1:0] cache_addr(input logic [31:0] r,
                                                  input logic [31:0] slot);
        return CAW'(r * 32'(CACHE_DEPTH) + slot);
    endfunction

    state_t state_reg, state_next;
    logic [RW-1:0]       r_reg, r_next;
    logic [WW-1:0]       w_reg, w_next;
    logic [IW-1:0]       idx_reg, idx_next;
    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic [FN_W-1:0]     addr_fn_reg, addr_fn_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    rem_reg, rem_next;
    logic [5:0]          off_reg, off_next;
    logic [WORD_W-1:0]   eff_reg, eff_next;
    logic [WORD_W-1:0]   word_reg, word_next;
    logic [1:0]          chunk_reg, chunk_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic                res_alloc_reg, res_alloc_next;
    logic [BAW-1:0]      clr_reg, clr_next;
    logic [CCW-1:0]      cache_count_reg [REGIONS];
    logic [CCW-1:0]      cache_count_next [REGIONS];
    logic [FN_W-1:0]     base_fn_reg [REGIONS];
    logic [FN_W-1:0]     base_fn_next [REGIONS];
    logic [FW-1:0]       frames_reg [REGIONS];
    logic [FW-1:0]       frames_next [REGIONS];
    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic                bm_we;
    logic [BAW-1:0]      bm_waddr, bm_raddr;
    logic [WORD_W-1:0]   bm_wdata, bm_rdata;
    logic                c_we;
    logic [CAW-1:0]      c_waddr, c_raddr;
    logic [IW-1:0]       c_wdata, c_rdata;

    logic                cfg_wr;
    logic [1:0]          reg_idx;
    logic [FW-1:0]       frames_sat;

    logic [FW-1:0]       cur_len;
    logic [FN_W-1:0]     cur_base;
    logic [CCW-1:0]      cur_cnt;
    logic [FN_W:0]       diff;
    logic                find_hit;
    logic [IW-1:0]       hit_idx;
    logic                last_region;
    logic [FW-1:0]       lrem;
    logic [WORD_W-1:0]   lim;
    logic [WORD_W-1:0]   eff;
    logic [3:0]          chunk_zero;
    logic [1:0]          first_chunk;
    logic [CHUNK_W-1:0]  pick_sel;
    logic [3:0]          pick_bit;
    logic [5:0]          pick_pos;
    logic [6:0]          space;
    logic [6:0]          run_n;
    logic [WORD_W-1:0]   run_ones;
    logic [WORD_W-1:0]   run_mask;
    logic [FN_W-1:0]     res_fn;

    pfa_ram #(.WIDTH(WORD_W), .DEPTH(BDEPTH)) u_bitmap (
        .aclk  (aclk),
        .we    (bm_we),
        .waddr (bm_waddr),
        .wdata (bm_wdata),
        .raddr (bm_raddr),
        .rdata (bm_rdata)
    );

    pfa_ram #(.WIDTH(IW), .DEPTH(CDEPTH)) u_cache (
        .aclk  (aclk),
        .we    (c_we),
        .waddr (c_waddr),
        .wdata (c_wdata),
        .raddr (c_raddr),
        .rdata (c_rdata)
    );

    // Configuration port.
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign reg_idx = paddr[4:3];

    always_comb begin
        if (FSW'(pwdata[CNT_W-1:0]) > FSW'(FRAMES_PER_REGION)) begin
            frames_sat = FW'(FRAMES_PER_REGION);
        end else begin
            frames_sat = FW'(pwdata[CNT_W-1:0]);
        end
    end

    always_comb begin
        base_fn_next = base_fn_reg;
        frames_next  = frames_reg;
        prdata       = '0;
        for (int i = 0; i < REGIONS && i < CFG_REGIONS; i++) begin
            if (cfg_wr && reg_idx == REG_BASE_IDX[i]) begin
                base_fn_next[i] = pwdata[ADDR_W-1:PAGE_W];
            end
            if (cfg_wr && reg_idx == REG_FRAMES_IDX[i]) begin
                frames_next[i] = frames_sat;
            end
            if (reg_idx == REG_BASE_IDX[i]) begin
                prdata = CFG_DATA_W'({base_fn_reg[i], {PAGE_W{1'b0}}});
            end
            if (reg_idx == REG_FRAMES_IDX[i]) begin
                prdata = CFG_DATA_W'(frames_reg[i]);
            end
        end
    end

    // Region datapath.
    assign cur_len     = frames_reg[r_reg];
    assign cur_base    = base_fn_reg[r_reg];
    assign cur_cnt     = cache_count_reg[r_reg];
    assign diff        = {1'b0, addr_fn_reg} - {1'b0, cur_base};
    assign find_hit    = !diff[FN_W] && (diff[FN_W-1:0] < FN_W'(cur_len));
    assign hit_idx     = IW'(diff[FN_W-1:0]);
    assign last_region = (r_reg == RW'(REGIONS - 1));

    // Scan datapath: frames past the region length read as used.
    assign lrem = cur_len - FW'({w_reg, 6'b000000});
    assign lim  = (lrem > FW'(63)) ? FULL_WORD : ((64'd1 << lrem[5:0]) - 64'd1);
    assign eff  = bm_rdata | ~lim;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            chunk_zero[k] = ~&eff[k*CHUNK_W +: CHUNK_W];
        end
        priority if (chunk_zero[0]) begin
            first_chunk = 2'd0;
        end else if (chunk_zero[1]) begin
            first_chunk = 2'd1;
        end else if (chunk_zero[2]) begin
            first_chunk = 2'd2;
        end else begin
            first_chunk = 2'd3;
        end
    end

    assign pick_sel = eff_reg[{chunk_reg, 4'b0000} +: CHUNK_W];

    always_comb begin
        pick_bit = 4'd0;
        for (int b = CHUNK_W - 1; b >= 0; b--) begin
            if (!pick_sel[b]) begin
                pick_bit = 4'(b);
            end
        end
    end

    assign pick_pos = {chunk_reg, pick_bit};

    // Reserve datapath: mask of the run within the current word.
    assign space    = 7'd64 - {1'b0, off_reg};
    assign run_n    = (rem_reg < CNT_W'(space)) ? rem_reg[6:0] : space;
    assign run_ones = run_n[6] ? FULL_WORD : ((64'd1 << run_n[5:0]) - 64'd1);
    assign run_mask = run_ones << off_reg;

    assign res_fn = cur_base + FN_W'(idx_reg);

    always_comb begin
        state_next       = state_reg;
        r_next           = r_reg;
        w_next           = w_reg;
        idx_next         = idx_reg;
        kind_next        = kind_reg;
        addr_fn_next     = addr_fn_reg;
        count_next       = count_reg;
        rem_next         = rem_reg;
        off_next         = off_reg;
        eff_next         = eff_reg;
        word_next        = word_reg;
        chunk_next       = chunk_reg;
        res_status_next  = res_status_reg;
        res_alloc_next   = res_alloc_reg;
        clr_next         = clr_reg;
        cache_count_next = cache_count_reg;
        m_tvalid_next    = m_tvalid_reg & ~m_tready;
        m_tdata_next     = m_tdata_reg;
        bm_we            = 1'b0;
        bm_waddr         = '0;
        bm_wdata         = '0;
        bm_raddr         = '0;
        c_we             = 1'b0;
        c_waddr          = '0;
        c_wdata          = '0;
        c_raddr          = '0;

        unique case (state_reg)
            ST_CLEAR: begin
                bm_we    = 1'b1;
                bm_waddr = clr_reg;
                if (clr_reg == BAW'(BDEPTH - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    kind_next      = s_tuser;
                    addr_fn_next   = s_tdata[ADDR_W-1:PAGE_W];
                    count_next     = s_tdata[ADDR_W+CNT_W-1:ADDR_W];
                    r_next         = '0;
                    res_alloc_next = 1'b0;
                    unique case (s_tuser)
                        KIND_ALLOC: begin
                            state_next = ST_A_REGION;
                        end
                        KIND_FREE, KIND_RESERVE: begin
                            if (s_tdata[PAGE_W-1:0] != '0) begin
                                res_status_next = STATUS_BAD;
                                state_next      = ST_DONE;
                            end else begin
                                state_next = ST_FIND;
                            end
                        end
                        default: begin
                            res_status_next = STATUS_BAD;
                            state_next      = ST_DONE;
                        end
                    endcase
                end
            end
            ST_A_REGION: begin
                if (cur_cnt != '0) begin
                    cache_count_next[r_reg] = cur_cnt - 1'b1;
                    c_raddr    = cache_addr(32'(r_reg), 32'(cur_cnt - 1'b1));
                    state_next = ST_A_POP;
                end else if (cur_len != '0) begin
                    w_next     = '0;
                    bm_raddr   = bm_addr(32'(r_reg), 32'd0);
                    state_next = ST_A_SCAN;
                end else if (last_region) begin
                    res_status_next = STATUS_NO_FREE;
                    state_next      = ST_DONE;
                end else begin
                    r_next = r_reg + 1'b1;
                end
            end
            ST_A_POP: begin
                if (FW'(c_rdata) < cur_len) begin
                    idx_next   = c_rdata;
                    bm_raddr   = bm_addr(32'(r_reg), 32'(c_rdata >> 6));
                    state_next = ST_A_SET;
                end else if (cur_len != '0) begin
                    w_next     = '0;
                    bm_raddr   = bm_addr(32'(r_reg), 32'd0);
                    state_next = ST_A_SCAN;
                end else if (last_region) begin
                    res_status_next = STATUS_NO_FREE;
                    state_next      = ST_DONE;
                end else begin
                    r_next     = r_reg + 1'b1;
                    state_next = ST_A_REGION;
                end
            end
            ST_A_SET: begin
                bm_we           = 1'b1;
                bm_waddr        = bm_addr(32'(r_reg), 32'(idx_reg >> 6));
                bm_wdata        = bm_rdata | (64'd1 << idx_reg[5:0]);
                res_status_next = STATUS_OK;
                res_alloc_next  = 1'b1;
                state_next      = ST_DONE;
            end
            ST_A_SCAN: begin
                if (eff != FULL_WORD) begin
                    eff_next   = eff;
                    word_next  = bm_rdata;
                    chunk_next = first_chunk;
                    state_next = ST_A_PICK;
                end else if (lrem > FW'(64)) begin
                    w_next   = w_reg + 1'b1;
                    bm_raddr = bm_addr(32'(r_reg), 32'(w_reg) + 32'd1);
                end else if (last_region) begin
                    res_status_next = STATUS_NO_FREE;
                    state_next      = ST_DONE;
                end else begin
                    r_next     = r_reg + 1'b1;
                    state_next = ST_A_REGION;
                end
            end
            ST_A_PICK: begin
                bm_we           = 1'b1;
                bm_waddr        = bm_addr(32'(r_reg), 32'(w_reg));
                bm_wdata        = word_reg | (64'd1 << pick_pos);
                idx_next        = IW'({w_reg, pick_pos});
                res_status_next = STATUS_OK;
                res_alloc_next  = 1'b1;
                state_next      = ST_DONE;
            end
            ST_FIND: begin
                if (find_hit) begin
                    idx_next = hit_idx;
                    if (kind_reg == KIND_FREE) begin
                        if (cur_cnt < CCW'(CACHE_DEPTH)) begin
                            c_we    = 1'b1;
                            c_waddr = cache_addr(32'(r_reg), 32'(cur_cnt));
                            c_wdata = hit_idx;
                            cache_count_next[r_reg] = cur_cnt + 1'b1;
                        end
                        bm_raddr   = bm_addr(32'(r_reg), 32'(hit_idx >> 6));
                        state_next = ST_F_CLR;
                    end else begin
                        state_next = ST_R_CHECK;
                    end
                end else if (last_region) begin
                    res_status_next = STATUS_BAD;
                    state_next      = ST_DONE;
                end else begin
                    r_next = r_reg + 1'b1;
                end
            end
            ST_F_CLR: begin
                bm_we           = 1'b1;
                bm_waddr        = bm_addr(32'(r_reg), 32'(idx_reg >> 6));
                bm_wdata        = bm_rdata & ~(64'd1 << idx_reg[5:0]);
                res_status_next = STATUS_OK;
                state_next      = ST_DONE;
            end
            ST_R_CHECK: begin
                if (32'(idx_reg) + 32'(count_reg) > 32'(cur_len)) begin
                    res_status_next = STATUS_BAD;
                    state_next      = ST_DONE;
                end else if (count_reg == '0) begin
                    res_status_next = STATUS_OK;
                    state_next      = ST_DONE;
                end else begin
                    rem_next   = count_reg;
                    off_next   = idx_reg[5:0];
                    w_next     = WW'(idx_reg >> 6);
                    bm_raddr   = bm_addr(32'(r_reg), 32'(idx_reg >> 6));
                    state_next = ST_R_RUN;
                end
            end
            ST_R_RUN: begin
                bm_we    = 1'b1;
                bm_waddr = bm_addr(32'(r_reg), 32'(w_reg));
                bm_wdata = bm_rdata | run_mask;
                if (rem_reg == CNT_W'(run_n)) begin
                    res_status_next = STATUS_OK;
                    state_next      = ST_DONE;
                end else begin
                    rem_next = rem_reg - CNT_W'(run_n);
                    off_next = '0;
                    w_next   = w_reg + 1'b1;
                    bm_raddr = bm_addr(32'(r_reg), 32'(w_reg) + 32'd1);
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_TDATA_W'({res_status_reg,
                        res_alloc_reg ? {res_fn, {PAGE_W{1'b0}}} : {ADDR_W{1'b0}}});
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            clr_reg         <= '0;
            r_reg           <= '0;
            m_tvalid_reg    <= 1'b0;
            for (int i = 0; i < REGIONS; i++) begin
                cache_count_reg[i] <= '0;
                base_fn_reg[i]     <= '0;
                frames_reg[i]      <= '0;
            end
        end else begin
            state_reg       <= state_next;
            clr_reg         <= clr_next;
            r_reg           <= r_next;
            m_tvalid_reg    <= m_tvalid_next;
            cache_count_reg <= cache_count_next;
            base_fn_reg     <= base_fn_next;
            frames_reg      <= frames_next;
        end
    end

    always_ff @(posedge aclk) begin
        w_reg          <= w_next;
        idx_reg        <= idx_next;
        kind_reg       <= kind_next;
        addr_fn_reg    <= addr_fn_next;
        count_reg      <= count_next;
        rem_reg        <= rem_next;
        off_reg        <= off_next;
        eff_reg        <= eff_next;
        word_reg       <= word_next;
        chunk_reg      <= chunk_next;
        res_status_reg <= res_status_next;
        res_alloc_reg  <= res_alloc_next;
        m_tdata_reg    <= m_tdata_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `PFA_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "accepted while busy")
    `PFA_ASSERT_NOW(a_cache_bound, 1'b1, cache_count_reg[0] <= CCW'(CACHE_DEPTH), "cache overrun")
    `PFA_ASSERT_NOW(a_result_from_done, $rose(m_tvalid), $past(state_reg == ST_DONE), "stray result")
    `PFA_ASSERT_NOW(a_addr_only_ok, m_tvalid && m_tdata[53:52] != STATUS_OK, m_tdata[51:0] == '0, "address on error")

endmodule

FILE: hdl/pfa_ram.sv
// ---------------------------------------------------------------------------
// Page frame allocator RAM
// Generic simple dual-port RAM with one write port and a registered read.
// ---------------------------------------------------------------------------
module pfa_ram import pfa_pkg::*; #(
    parameter int WIDTH = WORD_W,
    parameter int DEPTH = REGIONS_DEF * CACHE_DEPTH_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: tb/pfa_checker.sv
// ---------------------------------------------------------------------------
// Page frame allocator checker
// Watches the request, result and register ports of the allocator, keeps its
// own copy of the region registers, usage bitmaps and free-frame caches, works
// out the result of every accepted request and compares each result
// transaction in order, field by field.
// ---------------------------------------------------------------------------
module pfa_checker import pfa_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    // phys_addr [51:0], frame_count [64:52], zero padding above
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // kind [1:0]
    input  logic [KIND_W-1:0]     s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    // frame_addr [51:0], status [53:52], zero padding above
    input  logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    input  logic                  pready,
    output int                    fail_count,
    output int                    results_due,
    output int                    requests_seen,
    output int                    granted,
    output int                    from_cache,
    output int                    exhausted,
    output int                    rejected
);

    localparam int NREG       = REGIONS_DEF;
    localparam int WORDS      = (FRAMES_PER_REGION_DEF + WORD_W - 1) / WORD_W;
    localparam int CACHE      = CACHE_DEPTH_DEF;
    localparam int MAX_PRINTS = 200;

    typedef struct packed {
        logic [ADDR_W-1:0]   frame_addr;
        logic [STATUS_W-1:0] status;
    } grant_t;

    logic [ADDR_W-1:0] region_base [NREG];
    int                region_len  [NREG];
    logic [WORD_W-1:0] used_map    [NREG][WORDS];
    logic [PAGE_W-1:0] freed_stack [NREG][CACHE];
    int                stack_fill  [NREG];
    grant_t            pending_grants [$];

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        fail_count++;
        if (fail_count <= MAX_PRINTS) begin
            $display("mismatch at %0t: %s, got 0x%0h, wanted 0x%0h", $time, what, got, want);
        end
    endtask

    task automatic clear_model();
        int r, w, c;
        for (r = 0; r < NREG; r++) begin
            region_base[r] = '0;
            region_len[r]  = 0;
            stack_fill[r]  = 0;
            for (w = 0; w < WORDS; w++) used_map[r][w] = '0;
            for (c = 0; c < CACHE; c++) freed_stack[r][c] = '0;
        end
        pending_grants.delete();
        results_due   = 0;
        requests_seen = 0;
        granted       = 0;
        from_cache    = 0;
        exhausted     = 0;
        rejected      = 0;
    endtask

    function automatic logic frame_used(input int r, input int idx);
        return used_map[r][idx >> 6][idx & 63];
    endfunction

    task automatic mark_frame(input int r, input int idx, input logic used);
        used_map[r][idx >> 6][idx & 63] = used;
    endtask

    function automatic logic [ADDR_W-1:0] frame_addr_of(input int r, input int idx);
        return region_base[r] + (ADDR_W'(idx) << PAGE_W);
    endfunction

    // Region ends are reckoned in 64 bits, so a region may reach past the top
    // of the 52-bit space.
    function automatic int owner_of(input logic [ADDR_W-1:0] a);
        logic [63:0] lo, hi;
        int          r, found;
        found = NREG;
        for (r = NREG - 1; r >= 0; r--) begin
            lo = 64'(region_base[r]);
            hi = lo + (64'(region_len[r]) << PAGE_W);
            if (64'(a) >= lo && 64'(a) < hi) found = r;
        end
        return found;
    endfunction

    function automatic int clip_len(input logic [CNT_W-1:0] value);
        return (value > FRAMES_PER_REGION_DEF) ? FRAMES_PER_REGION_DEF : int'(value);
    endfunction

    task automatic apply_write(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] value);
        case (idx)
            REG_REGION0_BASE:   region_base[0] = {value[ADDR_W-1:PAGE_W], {PAGE_W{1'b0}}};
            REG_REGION0_FRAMES: region_len[0]  = clip_len(value[CNT_W-1:0]);
            REG_REGION1_BASE:   region_base[1] = {value[ADDR_W-1:PAGE_W], {PAGE_W{1'b0}}};
            REG_REGION1_FRAMES: region_len[1]  = clip_len(value[CNT_W-1:0]);
            default: ;
        endcase
    endtask

    task automatic predict_alloc(output grant_t g);
        int                r, idx;
        logic [PAGE_W-1:0] top;
        logic              hit;
        g.frame_addr = '0;
        g.status     = STATUS_NO_FREE;
        hit          = 1'b0;
        for (r = 0; r < NREG; r++) begin
            if (!hit && stack_fill[r] > 0) begin
                stack_fill[r]--;
                top = freed_stack[r][stack_fill[r]];
                // An entry beyond the current length is dropped and the region scanned.
                if (int'(top) < region_len[r]) begin
                    mark_frame(r, top, 1'b1);
                    g.frame_addr = frame_addr_of(r, top);
                    g.status     = STATUS_OK;
                    hit          = 1'b1;
                    from_cache++;
                end
            end
            for (idx = 0; idx < region_len[r] && !hit; idx++) begin
                if (!frame_used(r, idx)) begin
                    mark_frame(r, idx, 1'b1);
                    g.frame_addr = frame_addr_of(r, idx);
                    g.status     = STATUS_OK;
                    hit          = 1'b1;
                end
            end
        end
    endtask

    task automatic predict_free(input logic [ADDR_W-1:0] a, output grant_t g);
        int r, idx;
        g.frame_addr = '0;
        g.status     = STATUS_BAD;
        r            = owner_of(a);
        if (a[PAGE_W-1:0] == '0 && r < NREG) begin
            idx = int'((a - region_base[r]) >> PAGE_W);
            if (stack_fill[r] < CACHE) begin
                freed_stack[r][stack_fill[r]] = PAGE_W'(idx);
                stack_fill[r]++;
            end
            mark_frame(r, idx, 1'b0);
            g.status = STATUS_OK;
        end
    endtask

    task automatic predict_reserve(input logic [ADDR_W-1:0] a, input logic [CNT_W-1:0] count,
                                   output grant_t g);
        int r, idx, i;
        g.frame_addr = '0;
        g.status     = STATUS_BAD;
        r            = owner_of(a);
        if (a[PAGE_W-1:0] == '0 && r < NREG) begin
            idx = int'((a - region_base[r]) >> PAGE_W);
            if (idx + int'(count) <= region_len[r]) begin
                for (i = 0; i < int'(count); i++) mark_frame(r, idx + i, 1'b1);
                g.status = STATUS_OK;
            end
        end
    endtask

    task automatic check_grant(input logic [M_TDATA_W-1:0] beat);
        grant_t want;
        if (pending_grants.size() == 0) begin
            report_mismatch("result transaction with no request outstanding", 64'(beat), 64'd0);
        end else begin
            want = pending_grants.pop_front();
            results_due--;
            if (beat[ADDR_W-1:0] !== want.frame_addr) begin
                report_mismatch("frame_addr", 64'(beat[ADDR_W-1:0]), 64'(want.frame_addr));
            end
            if (beat[ADDR_W+STATUS_W-1:ADDR_W] !== want.status) begin
                report_mismatch("status", 64'(beat[ADDR_W+STATUS_W-1:ADDR_W]), 64'(want.status));
            end
        end
    endtask

    always @(posedge aclk) begin : observe
        grant_t g;
        if (!aresetn) begin
            clear_model();
        end else begin
            if (m_tvalid && m_tready) check_grant(m_tdata);
            if (psel && penable && pwrite && pready) apply_write(paddr[CFG_ADDR_W-1:3], pwdata);
            if (s_tvalid && s_tready) begin
                case (s_tuser)
                    KIND_ALLOC:   predict_alloc(g);
                    KIND_FREE:    predict_free(s_tdata[ADDR_W-1:0], g);
                    KIND_RESERVE: predict_reserve(s_tdata[ADDR_W-1:0],
                                                  s_tdata[ADDR_W+CNT_W-1:ADDR_W], g);
                    default: begin
                        g.frame_addr = '0;
                        g.status     = STATUS_BAD;
                    end
                endcase
                if (g.status == STATUS_BAD) rejected++;
                else if (g.status == STATUS_NO_FREE) exhausted++;
                else if (s_tuser == KIND_ALLOC) granted++;
                pending_grants.push_back(g);
                results_due++;
                requests_seen++;
            end
        end
    end

endmodule

FILE: tb/tb_page_frame_allocator.sv
// ---------------------------------------------------------------------------
// Page frame allocator testbench
// Drives allocate, free and reserve requests over a series of region layouts,
// first a directed set of corner cases and then random traffic, with random
// gaps on both streams and one long result back-pressure stretch. A checker
// beside the allocator predicts and compares every result transaction.
// ---------------------------------------------------------------------------
module tb_page_frame_allocator;
    import pfa_pkg::*;

    localparam int ITEMS_PER_PHASE = 135;
    localparam int RANDOM_PHASES   = 8;
    localparam int LONG_HOLD       = 400;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int TAIL_CYCLES     = 200;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [KIND_W-1:0]     s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    int fail_count, results_due, requests_seen, granted, from_cache, exhausted, rejected;

    logic [ADDR_W-1:0] cfg_base [2];
    int                cfg_len  [2];
    logic              gaps_on;
    logic              hold_request;
    int                reg_writes;
    int                quiet_cycles = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    page_frame_allocator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    pfa_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .fail_count    (fail_count),
        .results_due   (results_due),
        .requests_seen (requests_seen),
        .granted       (granted),
        .from_cache    (from_cache),
        .exhausted     (exhausted),
        .rejected      (rejected)
    );

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("no transaction for %0d cycles, %0d results outstanding",
                     quiet_cycles, results_due);
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (!gaps_on || roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [ADDR_W-1:0] frame_at(input int r, input int idx);
        return cfg_base[r] + (ADDR_W'(idx) << PAGE_W);
    endfunction

    initial begin : receiver
        int stall;
        stall    = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                stall        = LONG_HOLD;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 99) < 25) stall = pick_gap();
            end
        end
    end

    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [ADDR_W-1:0] addr,
                             input logic [CNT_W-1:0] count);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {{(S_TDATA_W - CNT_W - ADDR_W){1'b0}}, count, addr};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (results_due != 0) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        reg_writes++;
    endtask

    // With junk set, the bits that the registers drop are filled at random.
    task automatic set_region(input int r, input logic [ADDR_W-1:0] base,
                              input logic [CNT_W-1:0] len, input bit junk);
        logic [CFG_DATA_W-1:0] noise;
        noise = junk ? {$urandom, $urandom} : '0;
        write_reg((r == 0) ? REG_REGION0_BASE : REG_REGION1_BASE,
                  {noise[CFG_DATA_W-1:ADDR_W], base[ADDR_W-1:PAGE_W], noise[PAGE_W-1:0]});
        write_reg((r == 0) ? REG_REGION0_FRAMES : REG_REGION1_FRAMES,
                  {noise[CFG_DATA_W-1:CNT_W], len});
        cfg_base[r] = {base[ADDR_W-1:PAGE_W], {PAGE_W{1'b0}}};
        cfg_len[r]  = (len > FRAMES_PER_REGION_DEF) ? FRAMES_PER_REGION_DEF : int'(len);
    endtask

    function automatic logic [ADDR_W-1:0] random_base();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10) return '0;
        if (roll < 20) begin
            return {(ADDR_W - PAGE_W)'({(ADDR_W - PAGE_W){1'b1}} - $urandom_range(0, 200)),
                    {PAGE_W{1'b0}}};
        end
        return ADDR_W'({$urandom, $urandom});
    endfunction

    function automatic logic [CNT_W-1:0] random_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5) return '0;
        if (roll < 10) return CNT_W'($urandom);
        if (roll < 15) return CNT_W'(1);
        return CNT_W'($urandom_range(2, 160));
    endfunction

    task automatic random_item();
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] addr;
        logic [CNT_W-1:0]  count;
        int                r, roll, idx;
        roll  = $urandom_range(0, 99);
        r     = $urandom_range(0, 1);
        addr  = ADDR_W'({$urandom, $urandom});
        count = CNT_W'($urandom);
        idx   = (cfg_len[r] > 0) ? $urandom_range(0, cfg_len[r] - 1) : 0;
        if (roll < 45) begin
            kind = KIND_ALLOC;
        end else if (roll < 75) begin
            kind = KIND_FREE;
            if (cfg_len[r] > 0) addr = frame_at(r, idx);
        end else if (roll < 88) begin
            kind = KIND_RESERVE;
            if (cfg_len[r] > 0) addr = frame_at(r, idx);
            if ($urandom_range(0, 19) == 0) count = CNT_W'($urandom_range(0, cfg_len[r] - idx + 1));
            else count = CNT_W'($urandom_range(0, 6));
        end else begin
            kind = KIND_W'($urandom);
            if (roll < 94 && cfg_len[r] > 0) addr = frame_at(r, idx) + ADDR_W'($urandom_range(1, 4095));
        end
        send_item(kind, addr, count);
    endtask

    initial begin : stimulus
        int phase, n, r;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        gaps_on      = 1'b1;
        hold_request = 1'b0;
        reg_writes   = 0;
        for (r = 0; r < 2; r++) begin
            cfg_base[r] = '0;
            cfg_len[r]  = 0;
        end
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        // Both regions are empty after reset.
        send_item(KIND_ALLOC, ADDR_W'({$urandom, $urandom}), CNT_W'($urandom));
        send_item(KIND_FREE, '0, CNT_W'(1));
        drain();

        set_region(0, 52'h0_0000_4000_0000, CNT_W'(8), 1'b1);
        set_region(1, 52'h0_0000_8000_0000, CNT_W'(4), 1'b0);
        send_item(KIND_ALLOC, '0, '0);
        send_item(KIND_ALLOC, '1, '1);
        send_item(KIND_FREE, frame_at(0, 0), '0);
        send_item(KIND_ALLOC, '0, '0);
        send_item(KIND_FREE, frame_at(0, 0) + ADDR_W'(12'h800), '0);
        send_item(KIND_FREE, 52'hF_FFFF_FFFF_F000, '0);
        send_item(KIND_FREE, frame_at(0, 5), '0);
        send_item(KIND_RESERVE, frame_at(0, 2) + ADDR_W'(1), CNT_W'(1));
        send_item(KIND_RESERVE, frame_at(0, 6), CNT_W'(3));
        send_item(KIND_RESERVE, frame_at(0, 3), CNT_W'(0));
        send_item(KIND_RESERVE, frame_at(0, 2), CNT_W'(6));
        send_item(KIND_UNUSED, '1, '1);
        send_item(KIND_ALLOC, '0, '0);
        send_item(KIND_ALLOC, '0, '0);
        send_item(KIND_RESERVE, frame_at(1, 1), CNT_W'(3));
        send_item(KIND_ALLOC, '0, '0);
        send_item(KIND_FREE, '1, '0);
        send_item(KIND_RESERVE, frame_at(1, 0), '1);
        send_item(KIND_FREE, frame_at(1, 3), '0);
        send_item(KIND_FREE, frame_at(0, 7), '0);
        drain();

        // Shrinking the region leaves a cached frame beyond its new length.
        set_region(0, cfg_base[0], CNT_W'(4), 1'b0);
        send_item(KIND_ALLOC, '0, '0);
        send_item(KIND_ALLOC, '0, '0);
        drain();

        // Full-size regions, the second at the top of the address space so
        // that its frame addresses wrap.
        set_region(0, '0, '1, 1'b1);
        set_region(1, '1, CNT_W'(FRAMES_PER_REGION_DEF), 1'b1);
        send_item(KIND_RESERVE, frame_at(0, 0), CNT_W'(FRAMES_PER_REGION_DEF));
        send_item(KIND_ALLOC, '0, '0);
        send_item(KIND_ALLOC, '0, '0);
        send_item(KIND_FREE, '0, '0);
        send_item(KIND_ALLOC, '0, '0);
        send_item(KIND_RESERVE, frame_at(0, 0), CNT_W'(FRAMES_PER_REGION_DEF + 1));
        for (n = 0; n < 20; n++) random_item();

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain();
            for (r = 0; r < 2; r++) set_region(r, random_base(), random_len(), $urandom_range(0, 1));
            if (phase == 5) set_region(1, frame_at(0, cfg_len[0] / 2), random_len(), 1'b0);
            gaps_on = (phase != 2);
            if (phase == 4) hold_request = 1'b1;
            for (n = 0; n < ITEMS_PER_PHASE; n++) random_item();
        end

        drain();
        repeat (TAIL_CYCLES) @(negedge aclk);
        $display("Ran %0d requests over %0d register writes: %0d frames granted (%0d from cache),",
                 requests_seen, reg_writes, granted, from_cache);
        $display("%0d allocations found no free frame, %0d requests rejected as bad.",
                 exhausted, rejected);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: page_frame_allocator.f
+incdir+hdl
hdl/pfa_pkg.sv
hdl/pfa_ram.sv
hdl/page_frame_allocator.sv
tb/pfa_checker.sv
tb/tb_page_frame_allocator.sv
